// ===== hw/rtl/jmhp_pkg.sv =====
package jmhp_pkg;

    // Marker bytes of the file syntax.
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE    = 8'hD8;
    localparam logic [7:0] APP0_CODE   = 8'hE0;
    localparam logic [7:0] DHT_CODE    = 8'hC4;
    localparam logic [7:0] JPG_CODE    = 8'hC8;
    localparam logic [7:0] DAC_CODE    = 8'hCC;

    // Fixed header sizes in bytes, length field included.
    localparam logic [3:0] SOF_HDR_LEN  = 4'd8;
    localparam logic [3:0] JFIF_HDR_LEN = 4'd14;
    localparam logic [3:0] GEN_HDR_LEN  = 4'd2;

    // Width of the packed result item.
    localparam int RESULT_BITS = 82;
    localparam int RESULT_TDATA_BITS = 88;

    typedef enum logic [2:0] {
        PH_START0,
        PH_START1,
        PH_MARK0,
        PH_MARK1,
        PH_HEADER,
        PH_SKIP,
        PH_DONE
    } parse_phase_t;

    // Start-of-frame codes: C0 through CF, except DHT, JPG and DAC.
    function automatic logic is_sof(input logic [7:0] code);
        logic in_range;
        in_range = (code[7:4] == 4'hC);
        return in_range && !(code inside {DHT_CODE, JPG_CODE, DAC_CODE});
    endfunction

endpackage

// ===== hw/rtl/jpeg_marker_header_parser.sv =====
// Results are registered: a result item is presented in the cycle after the input item that causes it,
// or, while the output is busy, in the cycle after the result ahead of it has been taken.
// Throughput: one input item per cycle; input stalls only while two results wait.
// A waiting result moves to a spare register, so input is still taken behind it.
// Reset: aresetn is synchronous and active low; it clears the parser and both result slots.
// The parser also returns to its reset state after an item with s_tlast set.
module jpeg_marker_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream: one byte of the file per item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_last: final byte of the file
    // Result stream: one item per file.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] parse_status, [16:1] image_height, [32:17] image_width,
    // [40:33] component_count, [41] jfif_present, [49:42] density_unit,
    // [65:50] x_density, [81:66] y_density, [87:82] zero
    output logic [jmhp_pkg::RESULT_TDATA_BITS-1:0] m_tdata
);
    import jmhp_pkg::*;

    // Parser state.
    parse_phase_t phase_reg, phase_next;
    logic [3:0]   field_reg, field_next;
    logic [7:0]   marker_reg, marker_next;
    logic [15:0]  seg_len_reg, seg_len_next;
    logic [15:0]  skip_reg, skip_next;
    logic [39:0]  capture_reg, capture_next;

    // Captured header values.
    logic [15:0]  height_reg, height_next;
    logic [15:0]  width_reg, width_next;
    logic [7:0]   comps_reg, comps_next;
    logic [7:0]   unit_reg, unit_next;
    logic [15:0]  xdens_reg, xdens_next;
    logic [15:0]  ydens_reg, ydens_next;
    logic         sof_seen_reg, sof_seen_next;
    logic         jfif_seen_reg, jfif_seen_next;

    // Output register and the spare slot behind it.
    logic                   m_valid_reg;
    logic [RESULT_BITS-1:0] m_data_reg;
    logic                   spare_valid_reg;
    logic [RESULT_BITS-1:0] spare_data_reg;
    logic [RESULT_BITS-1:0] result_word;
    logic                   out_free;

    logic       s_accept;
    logic       fail;
    logic       stop;
    logic       emit;
    logic       marker_sof;
    logic       marker_jfif;
    logic [3:0] hdr_len;
    logic [4:0] field_plus_one;
    logic [15:0] skip_dec;

    // A byte may enter whenever the spare slot is empty. Each byte produces at
    // most one result, so a new result always finds a free slot.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !spare_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // Header size depends on the marker: an APP0 is read in full only until
    // the first one has been taken.
    assign marker_sof  = is_sof(marker_reg);
    assign marker_jfif = (marker_reg == APP0_CODE) && !jfif_seen_reg;
    assign hdr_len     = marker_sof  ? SOF_HDR_LEN :
                         marker_jfif ? JFIF_HDR_LEN : GEN_HDR_LEN;
    assign field_plus_one = {1'b0, field_reg} + 5'd1;
    assign skip_dec = (skip_reg != 16'd0) ? (skip_reg - 16'd1) : skip_reg;

    always_comb begin
        phase_next     = phase_reg;
        field_next     = field_reg;
        marker_next    = marker_reg;
        seg_len_next   = seg_len_reg;
        skip_next      = skip_reg;
        capture_next   = capture_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        comps_next     = comps_reg;
        unit_next      = unit_reg;
        xdens_next     = xdens_reg;
        ydens_next     = ydens_reg;
        sof_seen_next  = sof_seen_reg;
        jfif_seen_next = jfif_seen_reg;
        fail           = 1'b0;
        stop           = 1'b0;

        case (phase_reg)
            PH_START0: begin
                if (s_tdata == MARK_PREFIX) begin
                    phase_next = PH_START1;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_START1: begin
                if (s_tdata == SOI_CODE) begin
                    phase_next = PH_MARK0;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_MARK0: begin
                if (s_tdata == MARK_PREFIX) begin
                    phase_next = PH_MARK1;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_MARK1: begin
                marker_next = s_tdata;
                field_next  = 4'd0;
                phase_next  = PH_HEADER;
            end
            PH_HEADER: begin
                // The first two bytes are the big-endian length; the last five
                // bytes of the header are the fields that get captured.
                if (field_reg < 4'd2) begin
                    seg_len_next = {seg_len_reg[7:0], s_tdata};
                end
                capture_next = {capture_reg[31:0], s_tdata};
                if (field_plus_one >= {1'b0, hdr_len}) begin
                    if (seg_len_next < {12'd0, hdr_len}) begin
                        fail = 1'b1;
                    end else begin
                        if (marker_sof) begin
                            height_next   = capture_next[39:24];
                            width_next    = capture_next[23:8];
                            comps_next    = capture_next[7:0];
                            sof_seen_next = 1'b1;
                        end else if (marker_jfif) begin
                            unit_next      = capture_next[39:32];
                            xdens_next     = capture_next[31:16];
                            ydens_next     = capture_next[15:0];
                            jfif_seen_next = 1'b1;
                        end
                        skip_next  = seg_len_next - {12'd0, hdr_len};
                        field_next = 4'd0;
                        if (sof_seen_next && jfif_seen_next) begin
                            stop = 1'b1;
                        end else if (skip_next == 16'd0) begin
                            phase_next = PH_MARK0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end else begin
                    field_next = field_plus_one[3:0];
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = PH_MARK0;
                end
            end
            PH_DONE: begin
                // Bytes after the result are dropped until the end of the file.
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        if (fail || stop) begin
            phase_next = PH_DONE;
        end

        // The result reflects whatever this byte has committed.
        result_word = {ydens_next, xdens_next, unit_next, jfif_seen_next,
                       comps_next, width_next, height_next, !sof_seen_next};

        // The last byte of a file returns the parser to its reset state.
        if (s_tlast) begin
            phase_next     = PH_START0;
            field_next     = 4'd0;
            marker_next    = 8'd0;
            seg_len_next   = 16'd0;
            skip_next      = 16'd0;
            height_next    = 16'd0;
            width_next     = 16'd0;
            comps_next     = 8'd0;
            unit_next      = 8'd0;
            xdens_next     = 16'd0;
            ydens_next     = 16'd0;
            sof_seen_next  = 1'b0;
            jfif_seen_next = 1'b0;
        end
    end

    // One result per file: on an error, on both headers found, or at the end
    // of the stream, whichever comes first.
    assign emit = s_accept && (fail || stop || s_tlast) && (phase_reg != PH_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START0;
            field_reg     <= 4'd0;
            marker_reg    <= 8'd0;
            seg_len_reg   <= 16'd0;
            skip_reg      <= 16'd0;
            height_reg    <= 16'd0;
            width_reg     <= 16'd0;
            comps_reg     <= 8'd0;
            unit_reg      <= 8'd0;
            xdens_reg     <= 16'd0;
            ydens_reg     <= 16'd0;
            sof_seen_reg  <= 1'b0;
            jfif_seen_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg     <= phase_next;
            field_reg     <= field_next;
            marker_reg    <= marker_next;
            seg_len_reg   <= seg_len_next;
            skip_reg      <= skip_next;
            height_reg    <= height_next;
            width_reg     <= width_next;
            comps_reg     <= comps_next;
            unit_reg      <= unit_next;
            xdens_reg     <= xdens_next;
            ydens_reg     <= ydens_next;
            sof_seen_reg  <= sof_seen_next;
            jfif_seen_reg <= jfif_seen_next;
        end
    end

    // The capture shift register is always refilled before it is read.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            capture_reg <= capture_next;
        end
    end

    // A result that cannot go out at once waits in the spare slot. The spare
    // slot is older than any new result, so it moves out first. A new result
    // never arrives while the spare slot is full, because input is held then.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (spare_valid_reg) begin
                m_valid_reg     <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= emit;
            end
        end else if (emit) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (spare_valid_reg) begin
                m_data_reg <= spare_data_reg;
            end else if (emit) begin
                m_data_reg <= result_word;
            end
        end else if (emit) begin
            spare_data_reg <= result_word;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(RESULT_TDATA_BITS - RESULT_BITS){1'b0}}, m_data_reg};

endmodule

// ===== hw/rtl/jmhp_checker.sv =====
module jmhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [jmhp_pkg::RESULT_TDATA_BITS-1:0] m_tdata
);
    import jmhp_pkg::*;

    // A waiting result holds still until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Input is held back only while a result is waiting.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item pending after reset");

    // Without an APP0 header the density unit and x density fields stay zero.
    a_jfif: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[41] |-> m_tdata[65:42] == 24'd0)
        else $error("density fields set without APP0 header");

    // A failed parse without a frame header carries no image size.
    a_sof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[40:1] == 40'd0)
        else $error("image fields set without frame header");

endmodule

bind jpeg_marker_header_parser jmhp_checker u_jmhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
